// ===== rtl/core/thread_slot_round_robin_scheduler_unit_defines.svh =====
// assertion macros for the thread slot scheduler checker
`ifndef THREAD_SLOT_ROUND_ROBIN_SCHEDULER_UNIT_DEFINES_SVH
`define THREAD_SLOT_ROUND_ROBIN_SCHEDULER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define TSRR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define TSRR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/tsrr_pkg.sv =====
// types and codes shared by the thread slot scheduler files
package tsrr_pkg;

    localparam int SLOT_PORT_W = 4;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_CREATE = 2'd0;
    localparam kind_t KIND_TICK   = 2'd1;
    localparam kind_t KIND_EXIT   = 2'd2;
    localparam kind_t KIND_SWITCH = 2'd3;

    typedef logic [1:0] status_t;
    localparam status_t STATUS_DONE     = 2'd0;
    localparam status_t STATUS_NO_FREE  = 2'd1;
    localparam status_t STATUS_NO_READY = 2'd2;

    typedef logic [1:0] slot_state_t;
    localparam slot_state_t SLOT_UNUSED  = 2'd0;
    localparam slot_state_t SLOT_READY   = 2'd1;
    localparam slot_state_t SLOT_RUNNING = 2'd2;

    typedef struct packed {
        kind_t                  kind;
        logic [SLOT_PORT_W-1:0] target_slot;
        logic [63:0]            entry_addr;
    } req_t;

    typedef struct packed {
        status_t                status;
        logic [SLOT_PORT_W-1:0] result_slot;
        logic [SLOT_PORT_W-1:0] previous_slot;
        logic                   switched;
        logic [63:0]            running_entry;
        logic [63:0]            new_id;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic commit;
        logic rd_entry;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic  hit;
        logic  last;
    } sts_t;

endpackage

// ===== rtl/core/tsrr_stream_if.sv =====
// valid/ready stream channel carrying one payload per beat
interface tsrr_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

// ===== rtl/core/tsrr_datapath.sv =====
// slot table, entry memory, id counter, scan pointer and result register
module tsrr_datapath #(
    parameter int SLOTS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  tsrr_pkg::req_t req_data,
    input  tsrr_pkg::cmd_t cmd,
    output tsrr_pkg::sts_t sts,
    output tsrr_pkg::rsp_t rsp_data
);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

    tsrr_pkg::slot_state_t slot_state_reg [SLOTS];
    logic [SW-1:0]         running_reg;
    logic [63:0]           id_reg;

    tsrr_pkg::kind_t       kind_reg;
    logic [3:0]            target_reg;
    logic [63:0]           entry_reg;
    logic [SW-1:0]         prev_reg;
    logic [SW-1:0]         ptr_reg;
    logic [SW-1:0]         cnt_reg;
    logic                  found_reg;
    logic [SW-1:0]         sel_reg;

    tsrr_pkg::status_t     status_reg;
    logic [SW-1:0]         res_reg;
    logic [63:0]           new_id_reg;
    logic [63:0]           rdata_reg;
    tsrr_pkg::rsp_t        rsp_reg;

    logic [63:0]           entry_mem [SLOTS];

    tsrr_pkg::slot_state_t cur_state;
    logic                  hit;
    logic [SW-1:0]         tgt_idx;
    logic                  tgt_ok;

    assign cur_state = slot_state_reg[ptr_reg];
    assign hit = (kind_reg == tsrr_pkg::KIND_CREATE) ? (cur_state == tsrr_pkg::SLOT_UNUSED)
                                                     : (cur_state == tsrr_pkg::SLOT_READY);
    assign tgt_idx = SW'(target_reg);
    assign tgt_ok  = (32'(target_reg) < SLOTS) && (tgt_idx != prev_reg);

    assign sts.hit  = hit;
    assign sts.last = (cnt_reg == LAST);
    assign rsp_data = rsp_reg;

    // slot table, running slot and id counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_state_reg[i] <= (i == 0) ? tsrr_pkg::SLOT_RUNNING : tsrr_pkg::SLOT_UNUSED;
            end
            running_reg <= '0;
            id_reg      <= 64'd2;
        end
        else if (cmd.commit)
        begin
            case (kind_reg)
                tsrr_pkg::KIND_CREATE:
                begin
                    if (found_reg)
                    begin
                        slot_state_reg[sel_reg] <= tsrr_pkg::SLOT_READY;
                        id_reg                  <= id_reg + 64'd1;
                    end
                end
                tsrr_pkg::KIND_TICK:
                begin
                    if (found_reg)
                    begin
                        slot_state_reg[prev_reg] <= tsrr_pkg::SLOT_READY;
                        slot_state_reg[sel_reg]  <= tsrr_pkg::SLOT_RUNNING;
                        running_reg              <= sel_reg;
                    end
                end
                tsrr_pkg::KIND_EXIT:
                begin
                    // slot 0 ends up running even when it was the one exiting
                    if (prev_reg != '0)
                    begin
                        slot_state_reg[prev_reg] <= tsrr_pkg::SLOT_UNUSED;
                    end
                    slot_state_reg[0]        <= tsrr_pkg::SLOT_RUNNING;
                    running_reg              <= '0;
                end
                default:
                begin
                    if (tgt_ok)
                    begin
                        slot_state_reg[prev_reg] <= tsrr_pkg::SLOT_READY;
                        slot_state_reg[tgt_idx]  <= tsrr_pkg::SLOT_RUNNING;
                        running_reg              <= tgt_idx;
                    end
                end
            endcase
        end
    end

    // operation capture and scan pointer
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg   <= req_data.kind;
            target_reg <= req_data.target_slot;
            entry_reg  <= req_data.entry_addr;
            prev_reg   <= running_reg;
            found_reg  <= 1'b0;
            if (req_data.kind == tsrr_pkg::KIND_TICK)
            begin
                // round robin starts after the running slot, slot 0 skipped
                ptr_reg <= (running_reg == LAST) ? SW'(1) : running_reg + SW'(1);
                cnt_reg <= SW'(1);
            end
            else
            begin
                ptr_reg <= '0;
                cnt_reg <= '0;
            end
        end
        else if (cmd.scan_step)
        begin
            if (hit)
            begin
                found_reg <= 1'b1;
                sel_reg   <= ptr_reg;
            end
            if (kind_reg == tsrr_pkg::KIND_TICK && ptr_reg == LAST)
            begin
                ptr_reg <= SW'(1);
            end
            else
            begin
                ptr_reg <= ptr_reg + SW'(1);
            end
            cnt_reg <= cnt_reg + SW'(1);
        end
    end

    // result fields and entry memory
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            new_id_reg <= '0;
            status_reg <= tsrr_pkg::STATUS_DONE;
            case (kind_reg)
                tsrr_pkg::KIND_CREATE:
                begin
                    if (found_reg)
                    begin
                        res_reg            <= sel_reg;
                        new_id_reg         <= id_reg;
                        entry_mem[sel_reg] <= entry_reg;
                    end
                    else
                    begin
                        res_reg    <= '0;
                        status_reg <= tsrr_pkg::STATUS_NO_FREE;
                    end
                end
                tsrr_pkg::KIND_TICK:
                begin
                    res_reg <= found_reg ? sel_reg : prev_reg;
                    if (!found_reg)
                    begin
                        status_reg <= tsrr_pkg::STATUS_NO_READY;
                    end
                end
                tsrr_pkg::KIND_EXIT:
                begin
                    res_reg <= '0;
                end
                default:
                begin
                    res_reg <= tgt_ok ? tgt_idx : prev_reg;
                end
            endcase
        end
        if (cmd.rd_entry)
        begin
            rdata_reg <= entry_mem[running_reg];
        end
        if (cmd.load_out)
        begin
            rsp_reg.status        <= status_reg;
            rsp_reg.result_slot   <= tsrr_pkg::SLOT_PORT_W'(res_reg);
            rsp_reg.previous_slot <= tsrr_pkg::SLOT_PORT_W'(prev_reg);
            rsp_reg.switched      <= (running_reg != prev_reg);
            // slot 0 is the boot context and has no stored entry
            rsp_reg.running_entry <= (running_reg == '0) ? 64'd0 : rdata_reg;
            rsp_reg.new_id        <= new_id_reg;
        end
    end

endmodule

// ===== rtl/core/tsrr_ctrl.sv =====
// sequencer for accept, table scan, commit, entry read and result hand-off
module tsrr_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  tsrr_pkg::kind_t req_kind,
    output logic            req_ready,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    input  tsrr_pkg::sts_t  sts,
    output tsrr_pkg::cmd_t  cmd
);
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_COMMIT = 3'd2;
    localparam logic [2:0] S_READ   = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    if (req_kind == tsrr_pkg::KIND_CREATE || req_kind == tsrr_pkg::KIND_TICK)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_COMMIT;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.hit || sts.last)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_READ;
            end
            S_READ:
            begin
                cmd.rd_entry = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                // wait here only while an older beat is still unclaimed
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign rsp_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/core/thread_slot_round_robin_scheduler_unit.sv =====
// round-robin thread slot scheduler: one operation in, one result beat out
// req channel: kind (create, tick, exit, switch), target_slot, entry_addr.
// rsp channel: status, result_slot, previous_slot, switched, running_entry,
// new_id; exactly one rsp beat per accepted req beat, in order.
// from req accept to rsp valid: exit and switch go through commit, entry
// read and result load; create and tick first run the slot table scan, which
// looks at one slot per cycle and stops at the first match, at most SLOTS
// slots for create and SLOTS-1 for tick, as tick skips slot 0.
// one operation is in flight at a time; req ready is high only while idle,
// so the next item can be taken the cycle after its result is loaded for output.
// the rsp register holds a finished beat while the receiver stalls; the
// block takes and works on the next item meanwhile and holds that result
// until the register frees up.
// reset: slot 0 running, all other slots unused, next id 2, no rsp pending;
// entry values are undefined until a create writes them.
module thread_slot_round_robin_scheduler_unit #(
    parameter int SLOTS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    tsrr_stream_if.sink   req,
    tsrr_stream_if.source rsp
);
    tsrr_pkg::cmd_t cmd;
    tsrr_pkg::sts_t sts;
    tsrr_pkg::req_t req_data;
    tsrr_pkg::rsp_t rsp_data;

    assign req_data = req.data;
    assign rsp.data = rsp_data;

    tsrr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_kind  (req_data.kind),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    tsrr_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_data (req_data),
        .cmd      (cmd),
        .sts      (sts),
        .rsp_data (rsp_data)
    );

endmodule

// ===== rtl/core/tsrr_checker.sv =====
// port-level checks for the thread slot scheduler, bound to the top level
`include "thread_slot_round_robin_scheduler_unit_defines.svh"

module tsrr_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input tsrr_pkg::rsp_t rsp_data
);

    `TSRR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "rsp beat changed while stalled")

    `TSRR_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "req taken while an operation is in flight")

    `TSRR_ASSERT_SAME(a_fail_quiet, rsp_valid && rsp_data.status != tsrr_pkg::STATUS_DONE, !rsp_data.switched && rsp_data.new_id == 64'd0, "failed operation switched or gave an id")

    `TSRR_ASSERT_SAME(a_no_ready_keeps, rsp_valid && rsp_data.status == tsrr_pkg::STATUS_NO_READY, rsp_data.result_slot == rsp_data.previous_slot, "tick with no ready slot moved the running slot")

endmodule

bind thread_slot_round_robin_scheduler_unit tsrr_checker u_tsrr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

// ===== tb/sv/tb_thread_slot_round_robin_scheduler_unit.sv =====
// testbench for the round-robin thread slot scheduler with a shadow slot table
`timescale 1ns / 100ps

module tb_thread_slot_round_robin_scheduler_unit;

    localparam int SLOTS          = 16;
    localparam int TOTAL_OPS      = 1350;
    localparam int QUIET_OPS      = 150;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AT        = 300;
    localparam int DRAIN_AT       = 700;
    localparam int WATCHDOG_LIMIT = 3000;

    // shadow of the slot table; predicts one result beat per accepted op
    class slot_table_shadow;
        tsrr_pkg::slot_state_t            state_tbl[SLOTS];
        logic [63:0]                      entry_tbl[SLOTS];
        bit                               written[SLOTS];
        logic [tsrr_pkg::SLOT_PORT_W-1:0] cur_slot;
        logic [63:0]                      next_id;
        tsrr_pkg::rsp_t                   expected_rsp[$];
        int                               errors;
        int                               accepted;

        function new();
            for (int i = 0; i < SLOTS; i++)
            begin
                state_tbl[i] = tsrr_pkg::SLOT_UNUSED;
                entry_tbl[i] = '0;
                written[i]   = 1'b0;
            end
            state_tbl[0] = tsrr_pkg::SLOT_RUNNING;
            cur_slot     = '0;
            next_id      = 64'd2;
            errors       = 0;
            accepted     = 0;
        endfunction

        function void run_slot(logic [tsrr_pkg::SLOT_PORT_W-1:0] s, bit prev_ready);
            if (prev_ready)
                state_tbl[cur_slot] = tsrr_pkg::SLOT_READY;
            state_tbl[s] = tsrr_pkg::SLOT_RUNNING;
            cur_slot     = s;
        endfunction

        function void note_request(tsrr_pkg::req_t op);
            tsrr_pkg::rsp_t                   r;
            logic [tsrr_pkg::SLOT_PORT_W-1:0] prev;
            bit                               found;
            int                               cand;
            prev     = cur_slot;
            found    = 1'b0;
            r        = '0;
            accepted++;
            case (op.kind)
                tsrr_pkg::KIND_CREATE:
                begin
                    r.status = tsrr_pkg::STATUS_NO_FREE;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!found && state_tbl[i] == tsrr_pkg::SLOT_UNUSED)
                        begin
                            found          = 1'b1;
                            state_tbl[i]   = tsrr_pkg::SLOT_READY;
                            entry_tbl[i]   = op.entry_addr;
                            written[i]     = 1'b1;
                            r.new_id       = next_id;
                            next_id        = next_id + 64'd1;
                            r.result_slot  = i[tsrr_pkg::SLOT_PORT_W-1:0];
                            r.status       = tsrr_pkg::STATUS_DONE;
                        end
                    end
                end
                tsrr_pkg::KIND_TICK:
                begin
                    r.status = tsrr_pkg::STATUS_NO_READY;
                    // wrap past the top back to slot 1, never slot 0
                    for (int i = 1; i < SLOTS; i++)
                    begin
                        cand = int'(prev) + i;
                        if (cand >= SLOTS)
                            cand -= SLOTS - 1;
                        if (!found && cand != 0 && cand < SLOTS
                            && state_tbl[cand] == tsrr_pkg::SLOT_READY)
                        begin
                            found    = 1'b1;
                            run_slot(cand[tsrr_pkg::SLOT_PORT_W-1:0], 1'b1);
                            r.status = tsrr_pkg::STATUS_DONE;
                        end
                    end
                end
                tsrr_pkg::KIND_EXIT:
                begin
                    state_tbl[prev] = tsrr_pkg::SLOT_UNUSED;
                    run_slot('0, 1'b0);
                end
                default:
                begin
                    if (op.target_slot != prev)
                        run_slot(op.target_slot, 1'b1);
                end
            endcase
            if (op.kind != tsrr_pkg::KIND_CREATE)
                r.result_slot = cur_slot;
            r.previous_slot = prev;
            r.switched      = (cur_slot != prev);
            r.running_entry = (cur_slot == 0) ? 64'd0 : entry_tbl[cur_slot];
            expected_rsp.push_back(r);
        endfunction

        function void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
            if (act_v !== exp_v)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(tsrr_pkg::rsp_t got);
            tsrr_pkg::rsp_t exp_r;
            if (expected_rsp.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, expected none, actual %p",
                         $time, got);
                errors++;
                return;
            end
            exp_r = expected_rsp.pop_front();
            check_field("status", 64'(exp_r.status), 64'(got.status));
            check_field("result_slot", 64'(exp_r.result_slot), 64'(got.result_slot));
            check_field("previous_slot", 64'(exp_r.previous_slot), 64'(got.previous_slot));
            check_field("switched", 64'(exp_r.switched), 64'(got.switched));
            check_field("running_entry", exp_r.running_entry, got.running_entry);
            check_field("new_id", exp_r.new_id, got.new_id);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    tsrr_stream_if #(.payload_t(tsrr_pkg::req_t)) req_if ();
    tsrr_stream_if #(.payload_t(tsrr_pkg::rsp_t)) rsp_if ();

    thread_slot_round_robin_scheduler_unit #(
        .SLOTS (SLOTS)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    slot_table_shadow sb = new();

    bit no_idle     = 1'b0;
    bit hold_active = 1'b0;
    bit hold_done   = 1'b0;
    int idle_cycles = 0;

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        req_if.valid   = 1'b0;
        req_if.data    = '0;
        rsp_if.ready   = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // result side: check every accepted beat, track cycles with no progress
    always @(posedge clk)
    begin
        if (rsp_if.valid && rsp_if.ready)
            sb.check_result(rsp_if.data);
        if ((rsp_if.valid && rsp_if.ready) || (req_if.valid && req_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        do
            @(posedge clk);
        while (idle_cycles < WATCHDOG_LIMIT);
        $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // receiver: random stall bursts, one long hold so the block backs up
    initial
    begin
        forever
        begin
            if (sb.accepted >= HOLD_AT && !hold_done)
            begin
                hold_active = 1'b1;
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done   = 1'b1;
                hold_active = 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 2) == 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                rsp_if.ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    function automatic tsrr_pkg::req_t make_op(tsrr_pkg::kind_t k,
                                               logic [tsrr_pkg::SLOT_PORT_W-1:0] t,
                                               logic [63:0] e);
        tsrr_pkg::req_t op;
        op.kind        = k;
        op.target_slot = t;
        op.entry_addr  = e;
        return op;
    endfunction

    function automatic logic [63:0] rand_entry();
        case ($urandom_range(0, 7))
            0:       return 64'd0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic tsrr_pkg::req_t pick_op();
        int                               r;
        logic [tsrr_pkg::SLOT_PORT_W-1:0] t;
        tsrr_pkg::kind_t                  k;
        r = $urandom_range(0, 99);
        t = tsrr_pkg::SLOT_PORT_W'($urandom_range(0, SLOTS - 1));
        if (r < 30)
            k = tsrr_pkg::KIND_CREATE;
        else if (r < 60)
            k = tsrr_pkg::KIND_TICK;
        else if (r < 75)
            k = tsrr_pkg::KIND_EXIT;
        else
        begin
            k = tsrr_pkg::KIND_SWITCH;
            // never run a slot whose entry was never written
            if (t != 0 && !sb.written[t])
                t = '0;
        end
        return make_op(k, t, rand_entry());
    endfunction

    task automatic send_op(input tsrr_pkg::req_t op);
        req_if.valid <= 1'b1;
        req_if.data  <= op;
        do
            @(posedge clk);
        while (!req_if.ready);
        sb.note_request(op);
    endtask

    task automatic maybe_gap();
        if (!no_idle && !hold_active && $urandom_range(0, 3) == 0)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    // with nothing pending a gap has already dropped valid
    task automatic wait_drained();
        if (sb.expected_rsp.size() != 0)
        begin
            req_if.valid <= 1'b0;
            while (sb.expected_rsp.size() != 0)
                @(posedge clk);
        end
    endtask

    initial
    begin
        logic [63:0] e;
        wait (rst_n === 1'b1);
        @(posedge clk);

        // boot state: nothing ready, exit and switch on slot 0 are no-ops
        send_op(make_op(tsrr_pkg::KIND_TICK, 4'd0, 64'd0));
        maybe_gap();
        send_op(make_op(tsrr_pkg::KIND_EXIT, 4'd15, '1));
        maybe_gap();
        send_op(make_op(tsrr_pkg::KIND_SWITCH, 4'd0, 64'd0));
        maybe_gap();
        // fill every slot, then one create that finds no free slot
        for (int i = 1; i < SLOTS; i++)
        begin
            case (i)
                1:       e = 64'd0;
                2:       e = '1;
                3:       e = 64'h5555_5555_5555_5555;
                4:       e = 64'haaaa_aaaa_aaaa_aaaa;
                default: e = {$urandom, $urandom};
            endcase
            send_op(make_op(tsrr_pkg::KIND_CREATE, i[tsrr_pkg::SLOT_PORT_W-1:0], e));
            maybe_gap();
        end
        send_op(make_op(tsrr_pkg::KIND_CREATE, 4'd0, '1));
        maybe_gap();
        send_op(make_op(tsrr_pkg::KIND_TICK, 4'd15, 64'd0));
        maybe_gap();
        send_op(make_op(tsrr_pkg::KIND_SWITCH, 4'd15, 64'd0));
        maybe_gap();
        // switch to the slot already running
        send_op(make_op(tsrr_pkg::KIND_SWITCH, 4'd15, '1));
        maybe_gap();
        send_op(make_op(tsrr_pkg::KIND_EXIT, 4'd0, 64'd0));
        maybe_gap();
        // freed slot keeps its entry and runs again without a create
        send_op(make_op(tsrr_pkg::KIND_SWITCH, 4'd15, 64'd0));
        maybe_gap();
        send_op(make_op(tsrr_pkg::KIND_TICK, 4'd0, '1));
        maybe_gap();

        for (int n = sb.accepted; n < TOTAL_OPS; n++)
        begin
            if (n == DRAIN_AT)
                wait_drained();
            if (n >= TOTAL_OPS - QUIET_OPS)
                no_idle = 1'b1;
            send_op(pick_op());
            maybe_gap();
        end

        wait_drained();
        // create and tick operations run longest, as they scan the slot table
        repeat (SLOTS + 8) @(posedge clk);
        if (sb.errors == 0 && sb.expected_rsp.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/tsrr_pkg.sv
rtl/core/tsrr_stream_if.sv
rtl/core/tsrr_datapath.sv
rtl/core/tsrr_ctrl.sv
rtl/core/thread_slot_round_robin_scheduler_unit.sv
rtl/core/tsrr_checker.sv
tb/sv/tb_thread_slot_round_robin_scheduler_unit.sv
